@@ rtl/core/tfve_pkg.sv @@
`default_nettype none
package tfve_pkg;

  localparam int unsigned NAME_MAX    = 8;
  localparam int unsigned LINE_MAX    = 256;
  localparam int unsigned VALUE_MAX   = 64;
  localparam int unsigned LEN_SAT     = 127;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned NAME_W  = 8 * NAME_MAX;
  localparam int unsigned NLEN_W  = 4;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned POS_W   = $clog2(LINE_MAX);
  localparam int unsigned MATCH_W = $clog2(NAME_MAX + 2);
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CIDX_W-1:0] CFG_NAME_CHARS  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_NAME_LENGTH = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_VALUE_LIMIT = 2'd2;

  localparam logic [NAME_W-1:0] RST_NAME_CHARS  = 64'd1280065859;
  localparam logic [NLEN_W-1:0] RST_NAME_LENGTH = 4'd4;
  localparam logic [LEN_W-1:0]  RST_VALUE_LIMIT = 7'd16;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_DIGITS = 4'b0010,
    PH_VALUE  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_ABSENT    = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_SHORT     = 3'd4
  } status_e;

  typedef struct packed {
    logic [NAME_W-1:0] name_chars;
    logic [NLEN_W-1:0] name_len;
    logic [LEN_W-1:0]  limit;
  } cfg_t;

  // outcome of one input byte: an optional value byte and an optional summary
  typedef struct packed {
    logic             has_value;
    logic [7:0]       value_byte;
    logic             has_summary;
    status_e          status;
    logic [LEN_W-1:0] length;
  } step_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/tfve_front.sv @@
`default_nettype none
module tfve_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tfve_pkg::cfg_t cfg_i,
  input  wire logic           fire_i,
  input  wire logic [7:0]     line_byte_i,
  input  wire logic           end_of_line_i,
  output tfve_pkg::step_t     step_o
);
  import tfve_pkg::*;

  phase_e               phase_q, phase_d;
  logic [MATCH_W-1:0]   match_q, match_d;
  logic [LEN_W-1:0]     decl_q, decl_d;
  logic [LEN_W-1:0]     emit_q, emit_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  status_e              stat_q, stat_d;

  logic [7:0]           u;
  logic [NLEN_W-1:0]    eff_n;
  logic [LEN_W-1:0]     eff_lim;
  logic [7:0]           tag_ch;
  logic [MATCH_W:0]     match_inc;
  logic [MATCH_W:0]     match_end;
  logic [10:0]          acc;
  logic [LEN_W-1:0]     emit_inc;
  logic [2:0]           sel;
  status_e              fin;

  assign u       = to_upper(line_byte_i);
  assign eff_n   = (cfg_i.name_len > NLEN_W'(NAME_MAX)) ? NLEN_W'(NAME_MAX) : cfg_i.name_len;
  assign eff_lim = (cfg_i.limit > LEN_W'(VALUE_MAX)) ? LEN_W'(VALUE_MAX) : cfg_i.limit;

  assign sel = 3'(match_q - MATCH_W'(1));

  always_comb begin
    if (match_q == '0) begin
      tag_ch = CH_LT;
    end else if (NLEN_W'(match_q) <= eff_n) begin
      tag_ch = to_upper(cfg_i.name_chars[8*sel +: 8]);
    end else begin
      tag_ch = CH_COLON;
    end
  end

  assign match_inc = {1'b0, match_q} + (MATCH_W+1)'(1);
  assign match_end = (MATCH_W+1)'(eff_n) + (MATCH_W+1)'(2);
  assign acc       = {4'b0, decl_q} * 11'd10 + {7'b0, u[3:0]};
  assign emit_inc  = emit_q + LEN_W'(1);

  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    decl_d  = decl_q;
    emit_d  = emit_q;
    pos_d   = pos_q;
    stat_d  = stat_q;
    step_o  = '0;
    step_o.status = ST_FOUND;
    fin     = ST_ABSENT;

    if (phase_q != PH_DONE) begin
      if (line_byte_i == CH_NUL || pos_q >= POS_W'(LINE_MAX - 1)) begin
        // end of content
        case (phase_q)
          PH_SEARCH: stat_d = ST_ABSENT;
          PH_DIGITS: stat_d = ST_MALFORMED;
          PH_VALUE:  stat_d = ST_SHORT;
          default:   stat_d = stat_q;
        endcase
        phase_d = PH_DONE;
      end else begin
        pos_d = pos_q + POS_W'(1);
        case (phase_q)
          PH_SEARCH: begin
            if (u == tag_ch) begin
              match_d = match_inc[MATCH_W-1:0];
              if (match_inc >= match_end) begin
                phase_d = PH_DIGITS;
                decl_d  = '0;
              end
            end else begin
              match_d = (u == CH_LT) ? MATCH_W'(1) : '0;
            end
          end
          PH_DIGITS: begin
            if (u >= CH_ZERO && u <= CH_NINE) begin
              decl_d = (acc > 11'(LEN_SAT)) ? LEN_W'(LEN_SAT) : acc[LEN_W-1:0];
            end else if (u == CH_GT) begin
              if (decl_q >= eff_lim) begin
                stat_d  = ST_TOO_LONG;
                phase_d = PH_DONE;
              end else if (decl_q == '0) begin
                stat_d  = ST_FOUND;
                phase_d = PH_DONE;
              end else begin
                emit_d  = '0;
                phase_d = PH_VALUE;
              end
            end else begin
              stat_d  = ST_MALFORMED;
              phase_d = PH_DONE;
            end
          end
          PH_VALUE: begin
            step_o.has_value  = 1'b1;
            step_o.value_byte = u;
            emit_d = emit_inc;
            if (emit_inc >= decl_q) begin
              stat_d  = ST_FOUND;
              phase_d = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end

    if (end_of_line_i) begin
      case (phase_d)
        PH_SEARCH: fin = ST_ABSENT;
        PH_DIGITS: fin = ST_MALFORMED;
        PH_VALUE:  fin = ST_SHORT;
        default:   fin = stat_d;
      endcase
      step_o.has_summary = 1'b1;
      step_o.status      = fin;
      step_o.length      = (fin == ST_FOUND || fin == ST_SHORT) ? emit_d : '0;
      phase_d = PH_SEARCH;
      match_d = '0;
      decl_d  = '0;
      emit_d  = '0;
      pos_d   = '0;
      stat_d  = ST_ABSENT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      match_q <= '0;
      decl_q  <= '0;
      emit_q  <= '0;
      pos_q   <= '0;
      stat_q  <= ST_ABSENT;
    end else if (fire_i) begin
      phase_q <= phase_d;
      match_q <= match_d;
      decl_q  <= decl_d;
      emit_q  <= emit_d;
      pos_q   <= pos_d;
      stat_q  <= stat_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tfve_queue.sv @@
`default_nettype none
module tfve_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tfve_pkg::step_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output tfve_pkg::step_t      head_o,
  output logic                 not_empty_o
);
  import tfve_pkg::*;

  step_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tfve_back.sv @@
`default_nettype none
module tfve_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tfve_pkg::step_t              head_i,
  input  wire logic                         not_empty_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [7:0]                        value_byte_o,
  output logic                              is_summary_o,
  output logic [2:0]                        status_o,
  output logic [tfve_pkg::LEN_W-1:0]        value_length_o
);
  import tfve_pkg::*;

  // value part of the head entry already transferred, summary still pending
  logic val_sent_q, val_sent_d;
  logic show_value;
  logic xfer;

  assign show_value  = head_i.has_value && !val_sent_q;
  assign out_valid_o = not_empty_i;
  assign xfer        = out_valid_o && out_ready_i;

  assign value_byte_o   = show_value ? head_i.value_byte : 8'd0;
  assign is_summary_o   = !show_value;
  assign status_o       = show_value ? 3'(ST_FOUND) : 3'(head_i.status);
  assign value_length_o = show_value ? '0 : head_i.length;

  assign pop_o = xfer && (!show_value || !head_i.has_summary);

  always_comb begin
    val_sent_d = val_sent_q;
    if (pop_o) begin
      val_sent_d = 1'b0;
    end else if (xfer && show_value) begin
      val_sent_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_sent_q <= 1'b0;
    end else begin
      val_sent_q <= val_sent_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tagged_field_value_extractor_unit.sv @@
`default_nettype none
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o     line_byte_i, end_of_line_i
// out       out_valid_o / out_ready_i   value_byte_o, is_summary_o, status_o, value_length_o
// cfg       cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// One byte is accepted per cycle while the 4-entry result queue has room.
// A byte that yields both a value byte and the line summary is delivered as
// a value transfer then a summary transfer; every other byte yields at most one result.
// Each result is registered in the result queue before it is offered on out_valid_o.
// Reset clears the parser to the start of a line and loads the default
// field name, name length and value limit; no clearing pass.
module tagged_field_value_extractor_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tfve_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  wire logic [tfve_pkg::NAME_W-1:0]  cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [7:0]                   line_byte_i,
  input  wire logic                         end_of_line_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [7:0]                        value_byte_o,
  output logic                              is_summary_o,
  output logic [2:0]                        status_o,
  output logic [tfve_pkg::LEN_W-1:0]        value_length_o
);
  import tfve_pkg::*;

  cfg_t  cfg_q, cfg_d;
  step_t step;
  step_t head;
  logic  in_fire;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NAME_CHARS:  cfg_d.name_chars = cfg_wdata_i;
        CFG_NAME_LENGTH: cfg_d.name_len   = cfg_wdata_i[NLEN_W-1:0];
        CFG_VALUE_LIMIT: cfg_d.limit      = cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.name_chars <= RST_NAME_CHARS;
      cfg_q.name_len   <= RST_NAME_LENGTH;
      cfg_q.limit      <= RST_VALUE_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = !q_full;
  assign in_fire    = in_valid_i && in_ready_o;

  tfve_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .fire_i        (in_fire),
    .line_byte_i   (line_byte_i),
    .end_of_line_i (end_of_line_i),
    .step_o        (step)
  );

  tfve_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && (step.has_value || step.has_summary)),
    .push_data_i (step),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (head),
    .not_empty_o (q_not_empty)
  );

  tfve_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .not_empty_i    (q_not_empty),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_byte_o   (value_byte_o),
    .is_summary_o   (is_summary_o),
    .status_o       (status_o),
    .value_length_o (value_length_o)
  );

endmodule
`default_nettype wire
